@@ rtl/bilinear_height_sampler_defines.svh @@
// assertion macros for the bilinear height sampler checker
`ifndef BILINEAR_HEIGHT_SAMPLER_DEFINES_SVH
`define BILINEAR_HEIGHT_SAMPLER_DEFINES_SVH

// same-cycle implication, off during reset
`define BHS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bhs assertion failed");

// next-cycle implication, off during reset
`define BHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bhs assertion failed");

// next-cycle implication, always on
`define BHS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bhs assertion failed");

`endif

@@ rtl/bhs_pkg.sv @@
// types, constants and helpers shared by the bilinear height sampler
package bhs_pkg;

   localparam int MAX_GRID_DIM = 256;
   localparam int IDX_W        = $clog2(MAX_GRID_DIM);
   localparam int STORE_DEPTH  = MAX_GRID_DIM * MAX_GRID_DIM;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);

   localparam int HEIGHT_W   = 24;
   localparam int POS_W      = 32;
   localparam int SCALE_W    = 32;
   localparam int DIM_W      = 9;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 72;
   localparam int ACC_W      = 58;

   localparam logic [40:0]      COORD_LIMIT = 41'd1 << 40;
   localparam logic [42:0]      HALF_TEXEL  = 43'd32768;
   localparam logic [ACC_W-1:0] ROUND_HALF  = 58'd1 << 31;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y      = 3'd5;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOAD,
      S_DIFF,
      S_MULX,
      S_MULY,
      S_CRDY,
      S_CLAMP,
      S_RD0,
      S_RD1,
      S_RD2,
      S_RD3,
      S_RD4,
      S_TOPM,
      S_BOTM,
      S_BOTA,
      S_SUB,
      S_HIM,
      S_LOM,
      S_ACC,
      S_RND,
      S_DONE
   } bhs_state_type;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [HEIGHT_W-1:0] wr_data;
      logic [ADDR_W-1:0]   rd_addr;
   } store_ctrl_type;

   function automatic logic [ADDR_W-1:0] texel_addr(input logic [IDX_W-1:0] col,
                                                    input logic [IDX_W-1:0] row);
      return ADDR_W'(int'(row) * MAX_GRID_DIM + int'(col));
   endfunction

endpackage

@@ rtl/bilinear_height_sampler.sv @@
// bilinear height sampler top level: sequencer, shared multiplier and registers
//
// req channel carries one item: a load (tuser 0) writes height_value at
// (load_col, load_row) and updates the running min/max; a sample (tuser 1)
// returns the bilinear interpolation of the four clamped neighbor texels.
// rsp channel returns one item per request: height_out (zero for a load or for a
// sample with zero scale or size), min_height and max_height after the request.
// csr channel writes configuration registers by index, always ready outside
// reset; write only while no request is in flight (not enforced by the block).
// A new request is taken only after the result of the last one is
// registered in the response register, so requests do not overlap. Samples are
// slowed by one 33x33 multiplier shared by six products and by the single read
// port of the height memory (four reads). Reset clears the min/max, the
// response and the origin and scale registers, sets the grid size to 256 and
// returns the sequencer to idle; the height memory keeps its contents. While
// rsp_tready is low a finished result waits in the response register and the
// next request is already taken and worked on.
module bilinear_height_sampler
   import bhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // load_col, load_row, height_value, pos_x, pos_y
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // height_out, min_height, max_height
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_data
);

   bhs_state_type state_ff, state_in;

   logic [DIM_W-1:0]    cols_ff, cols_in;
   logic [DIM_W-1:0]    rows_ff, rows_in;
   logic [POS_W-1:0]    orgx_ff, orgx_in;
   logic [POS_W-1:0]    orgy_ff, orgy_in;
   logic [SCALE_W-1:0]  sclx_ff, sclx_in;
   logic [SCALE_W-1:0]  scly_ff, scly_in;

   logic [7:0]          col_ff, col_in;
   logic [7:0]          row_ff, row_in;
   logic [HEIGHT_W-1:0] hgt_ff, hgt_in;
   logic [POS_W-1:0]    posx_ff, posx_in;
   logic [POS_W-1:0]    posy_ff, posy_in;
   logic                negx_ff, negx_in;
   logic                negy_ff, negy_in;
   logic [31:0]         magx_ff, magx_in;
   logic [31:0]         magy_ff, magy_in;
   logic [65:0]         mul_ff;
   logic signed [65:0]  mul_in;
   logic [26:0]         ix_ff, ix_in;
   logic [26:0]         iy_ff, iy_in;
   logic [FRAC_W-1:0]   fx_ff, fx_in;
   logic [FRAC_W-1:0]   fy_ff, fy_in;
   logic [IDX_W-1:0]    x0_ff, x0_in, x1_ff, x1_in;
   logic [IDX_W-1:0]    y0_ff, y0_in, y1_ff, y1_in;
   logic [HEIGHT_W-1:0] h00_ff, h00_in, h10_ff, h10_in;
   logic [HEIGHT_W-1:0] h01_ff, h01_in, h11_ff, h11_in;
   logic [40:0]         top_ff, top_in;
   logic [40:0]         bot_ff, bot_in;
   logic [41:0]         diff_ff, diff_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [HEIGHT_W-1:0] res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [32:0]  mul_a, mul_b;
   logic                req_accept;
   logic                csr_write;
   logic                rsp_load;
   logic                zero_case;
   logic                load_ok;
   logic [DIM_W-1:0]    ncols_m1, nrows_m1;
   logic [HEIGHT_W-1:0] store_rd_data;
   logic [HEIGHT_W-1:0] min_height, max_height;
   store_ctrl_type      store_ctrl;

   function automatic logic [42:0] map_coord(input logic [63:0] prod, input logic neg);
      logic [40:0] sat;
      logic [42:0] mag;
      sat = (prod > {23'd0, COORD_LIMIT}) ? COORD_LIMIT : prod[40:0];
      mag = {2'b00, sat};
      return neg ? (43'd0 - mag - HALF_TEXEL) : (mag - HALF_TEXEL);
   endfunction

   function automatic logic [IDX_W-1:0] clamp_index(input logic [26:0] idx,
                                                    input logic [DIM_W-1:0] nm1);
      if (idx[26]) begin
         return '0;
      end else if (idx > {18'd0, nm1}) begin
         return IDX_W'(nm1);
      end else begin
         return IDX_W'(idx);
      end
   endfunction

   bhs_store u_store (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (store_ctrl),
      .rd_data    (store_rd_data),
      .min_height (min_height),
      .max_height (max_height)
   );

   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = !reset;
   assign csr_write  = csr_valid && csr_ready;
   assign zero_case  = (sclx_ff == '0) || (scly_ff == '0) || (cols_ff == '0) || (rows_ff == '0);
   assign load_ok    = (32'(col_ff) < MAX_GRID_DIM) && (32'(row_ff) < MAX_GRID_DIM);
   assign ncols_m1   = ((32'(cols_ff) > MAX_GRID_DIM) ? DIM_W'(MAX_GRID_DIM) : cols_ff) - 9'd1;
   assign nrows_m1   = ((32'(rows_ff) > MAX_GRID_DIM) ? DIM_W'(MAX_GRID_DIM) : rows_ff) - 9'd1;
   assign mul_in     = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == OP_LOAD) begin
                  state_in = S_LOAD;
               end else if (zero_case) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_DIFF;
               end
            end
         end
         S_LOAD:  state_in = S_DONE;
         S_DIFF:  state_in = S_MULX;
         S_MULX:  state_in = S_MULY;
         S_MULY:  state_in = S_CRDY;
         S_CRDY:  state_in = S_CLAMP;
         S_CLAMP: state_in = S_RD0;
         S_RD0:   state_in = S_RD1;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = S_RD3;
         S_RD3:   state_in = S_RD4;
         S_RD4:   state_in = S_TOPM;
         S_TOPM:  state_in = S_BOTM;
         S_BOTM:  state_in = S_BOTA;
         S_BOTA:  state_in = S_SUB;
         S_SUB:   state_in = S_HIM;
         S_HIM:   state_in = S_LOM;
         S_LOM:   state_in = S_ACC;
         S_ACC:   state_in = S_RND;
         S_RND:   state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      logic [24:0] hdiff_top;
      logic [24:0] hdiff_bot;
      hdiff_top          = {h10_ff[23], h10_ff} - {h00_ff[23], h00_ff};
      hdiff_bot          = {h11_ff[23], h11_ff} - {h01_ff[23], h01_ff};
      req_tready         = 1'b0;
      rsp_load           = 1'b0;
      mul_a              = '0;
      mul_b              = '0;
      store_ctrl.wr_en   = 1'b0;
      store_ctrl.wr_addr = texel_addr(IDX_W'(col_ff), IDX_W'(row_ff));
      store_ctrl.wr_data = hgt_ff;
      store_ctrl.rd_addr = texel_addr(x0_ff, y0_ff);
      unique case (state_ff)
         S_IDLE:  req_tready = !reset;
         S_LOAD:  store_ctrl.wr_en = load_ok;
         S_MULX: begin
            mul_a = {1'b0, magx_ff};
            mul_b = {1'b0, sclx_ff};
         end
         S_MULY: begin
            mul_a = {1'b0, magy_ff};
            mul_b = {1'b0, scly_ff};
         end
         S_RD0:   store_ctrl.rd_addr = texel_addr(x0_ff, y0_ff);
         S_RD1:   store_ctrl.rd_addr = texel_addr(x1_ff, y0_ff);
         S_RD2:   store_ctrl.rd_addr = texel_addr(x0_ff, y1_ff);
         S_RD3:   store_ctrl.rd_addr = texel_addr(x1_ff, y1_ff);
         S_TOPM: begin
            mul_a = {{8{hdiff_top[24]}}, hdiff_top};
            mul_b = {17'd0, fx_ff};
         end
         S_BOTM: begin
            mul_a = {{8{hdiff_bot[24]}}, hdiff_bot};
            mul_b = {17'd0, fx_ff};
         end
         S_HIM: begin
            mul_a = {{7{diff_ff[41]}}, diff_ff[41:16]};
            mul_b = {17'd0, fy_ff};
         end
         S_LOM: begin
            mul_a = {17'd0, diff_ff[15:0]};
            mul_b = {17'd0, fy_ff};
         end
         S_DONE:  rsp_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      logic [32:0]      dx;
      logic [32:0]      dy;
      logic [32:0]      ndx;
      logic [32:0]      ndy;
      logic [42:0]      crd;
      logic [ACC_W-1:0] rnd;
      dx  = {posx_ff[31], posx_ff} - {orgx_ff[31], orgx_ff};
      dy  = {posy_ff[31], posy_ff} - {orgy_ff[31], orgy_ff};
      ndx = 33'd0 - dx;
      ndy = 33'd0 - dy;
      crd = map_coord(mul_ff[63:0], (state_ff == S_MULY) ? negx_ff : negy_ff);
      rnd = acc_ff + ROUND_HALF;

      cols_in = cols_ff;
      rows_in = rows_ff;
      orgx_in = orgx_ff;
      orgy_in = orgy_ff;
      sclx_in = sclx_ff;
      scly_in = scly_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS: cols_in = csr_data[DIM_W-1:0];
            CSR_GRID_ROWS:    rows_in = csr_data[DIM_W-1:0];
            CSR_ORIGIN_X:     orgx_in = csr_data;
            CSR_ORIGIN_Y:     orgy_in = csr_data;
            CSR_SCALE_X:      sclx_in = csr_data;
            CSR_SCALE_Y:      scly_in = csr_data;
            default: ;
         endcase
      end

      col_in  = col_ff;
      row_in  = row_ff;
      hgt_in  = hgt_ff;
      posx_in = posx_ff;
      posy_in = posy_ff;
      negx_in = negx_ff;
      negy_in = negy_ff;
      magx_in = magx_ff;
      magy_in = magy_ff;
      ix_in   = ix_ff;
      iy_in   = iy_ff;
      fx_in   = fx_ff;
      fy_in   = fy_ff;
      x0_in   = x0_ff;
      x1_in   = x1_ff;
      y0_in   = y0_ff;
      y1_in   = y1_ff;
      h00_in  = h00_ff;
      h10_in  = h10_ff;
      h01_in  = h01_ff;
      h11_in  = h11_ff;
      top_in  = top_ff;
      bot_in  = bot_ff;
      diff_in = diff_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               col_in  = req_tdata[7:0];
               row_in  = req_tdata[15:8];
               hgt_in  = req_tdata[39:16];
               posx_in = req_tdata[71:40];
               posy_in = req_tdata[103:72];
               res_in  = '0;
            end
         end
         S_DIFF: begin
            negx_in = dx[32];
            negy_in = dy[32];
            magx_in = dx[32] ? ndx[31:0] : dx[31:0];
            magy_in = dy[32] ? ndy[31:0] : dy[31:0];
         end
         S_MULY: begin
            ix_in = crd[42:16];
            fx_in = crd[15:0];
         end
         S_CRDY: begin
            iy_in = crd[42:16];
            fy_in = crd[15:0];
         end
         S_CLAMP: begin
            x0_in = clamp_index(ix_ff, ncols_m1);
            x1_in = clamp_index(ix_ff + 27'd1, ncols_m1);
            y0_in = clamp_index(iy_ff, nrows_m1);
            y1_in = clamp_index(iy_ff + 27'd1, nrows_m1);
         end
         S_RD1:  h00_in = store_rd_data;
         S_RD2:  h10_in = store_rd_data;
         S_RD3:  h01_in = store_rd_data;
         S_RD4:  h11_in = store_rd_data;
         S_BOTM: top_in = {h00_ff[23], h00_ff, 16'd0} + mul_ff[40:0];
         S_BOTA: bot_in = {h01_ff[23], h01_ff, 16'd0} + mul_ff[40:0];
         S_SUB:  diff_in = {bot_ff[40], bot_ff} - {top_ff[40], top_ff};
         S_LOM:  acc_in = {top_ff[40], top_ff, 16'd0} + {mul_ff[41:0], 16'd0};
         S_ACC:  acc_in = acc_ff + {26'd0, mul_ff[31:0]};
         S_RND:  res_in = rnd[32+HEIGHT_W-1:32];
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {max_height, min_height, res_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cols_ff      <= 9'd256;
         rows_ff      <= 9'd256;
         orgx_ff      <= '0;
         orgy_ff      <= '0;
         sclx_ff      <= '0;
         scly_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         orgx_ff      <= orgx_in;
         orgy_ff      <= orgy_in;
         sclx_ff      <= sclx_in;
         scly_ff      <= scly_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      hgt_ff      <= hgt_in;
      posx_ff     <= posx_in;
      posy_ff     <= posy_in;
      negx_ff     <= negx_in;
      negy_ff     <= negy_in;
      magx_ff     <= magx_in;
      magy_ff     <= magy_in;
      mul_ff      <= mul_in;
      ix_ff       <= ix_in;
      iy_ff       <= iy_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      h00_ff      <= h00_in;
      h10_ff      <= h10_in;
      h01_ff      <= h01_in;
      h11_ff      <= h11_in;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      diff_ff     <= diff_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/bhs_store.sv @@
// height memory with running minimum and maximum of loaded heights
module bhs_store
   import bhs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  store_ctrl_type      ctrl,
   output logic [HEIGHT_W-1:0] rd_data,
   output logic [HEIGHT_W-1:0] min_height,
   output logic [HEIGHT_W-1:0] max_height
);

   logic [HEIGHT_W-1:0] store_mem_ff [0:STORE_DEPTH-1];
   logic [HEIGHT_W-1:0] rd_data_ff;
   logic [HEIGHT_W-1:0] lowest_ff, lowest_in;
   logic [HEIGHT_W-1:0] highest_ff, highest_in;
   logic                any_loaded_ff, any_loaded_in;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         store_mem_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
      rd_data_ff <= store_mem_ff[ctrl.rd_addr];
   end

   always_comb begin
      lowest_in     = lowest_ff;
      highest_in    = highest_ff;
      any_loaded_in = any_loaded_ff;
      if (ctrl.wr_en) begin
         any_loaded_in = 1'b1;
         if (!any_loaded_ff) begin
            lowest_in  = ctrl.wr_data;
            highest_in = ctrl.wr_data;
         end else begin
            if ($signed(ctrl.wr_data) < $signed(lowest_ff)) begin
               lowest_in = ctrl.wr_data;
            end
            if ($signed(ctrl.wr_data) > $signed(highest_ff)) begin
               highest_in = ctrl.wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff     <= '0;
         highest_ff    <= '0;
         any_loaded_ff <= 1'b0;
      end else begin
         lowest_ff     <= lowest_in;
         highest_ff    <= highest_in;
         any_loaded_ff <= any_loaded_in;
      end
   end

   assign rd_data    = rd_data_ff;
   assign min_height = lowest_ff;
   assign max_height = highest_ff;

endmodule

@@ rtl/bhs_checker.sv @@
// port-level assertions for the bilinear height sampler, bound to the top level
`include "bilinear_height_sampler_defines.svh"

module bhs_checker
   import bhs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic signed [HEIGHT_W-1:0] rsp_min;
   logic signed [HEIGHT_W-1:0] rsp_max;

   assign rsp_min = rsp_tdata[47:24];
   assign rsp_max = rsp_tdata[71:48];

   `BHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `BHS_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)
   `BHS_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
   `BHS_ASSERT_IMPLY(a_min_le_max, clock, reset, rsp_tvalid, rsp_min <= rsp_max)

endmodule

bind bilinear_height_sampler bhs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ verif/tb_top.sv @@
// testbench for the bilinear height sampler: directed and random items checked by a predictor
module tb_top;
   import bhs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int RANDOM_GOAL     = 1670;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int END_WAIT        = 25;

   typedef struct packed {
      logic [HEIGHT_W-1:0] highest;
      logic [HEIGHT_W-1:0] lowest;
      logic [HEIGHT_W-1:0] height;
   } height_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [31:0]           csr_data;

   // predictor state
   logic signed [HEIGHT_W-1:0] height_mem [STORE_DEPTH];
   bit                         texel_written [STORE_DEPTH];
   logic signed [HEIGHT_W-1:0] lowest_height = '0;
   logic signed [HEIGHT_W-1:0] highest_height = '0;
   bit                         any_height = 1'b0;
   logic [DIM_W-1:0]           cfg_cols = 9'd256;
   logic [DIM_W-1:0]           cfg_rows = 9'd256;
   logic [POS_W-1:0]           cfg_org_x = '0;
   logic [POS_W-1:0]           cfg_org_y = '0;
   logic [SCALE_W-1:0]         cfg_scale_x = '0;
   logic [SCALE_W-1:0]         cfg_scale_y = '0;

   height_rsp_type height_expect_q [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          items_sent = 0;
   bit          req_idle_on = 1'b0;
   bit          rsp_idle_on = 1'b0;
   bit          rsp_hold_request = 1'b0;

   bilinear_height_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int gap_cycles(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 60);
   endfunction

   function automatic int span_of(input logic [DIM_W-1:0] dim);
      if (dim == 0) return 1;
      if (dim > MAX_GRID_DIM) return MAX_GRID_DIM;
      return int'(dim);
   endfunction

   function automatic longint clamp_idx(input longint i, input longint n);
      if (i < 0) return 0;
      if (i > n - 1) return n - 1;
      return i;
   endfunction

   // grid coordinate in Q.16: floor index and fractional weight
   function automatic void map_axis(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] org,
                                    input logic [SCALE_W-1:0] scl, output longint idx,
                                    output longint frac);
      longint     d;
      longint     t;
      logic [63:0] mag;
      logic [63:0] prod;
      d = longint'($signed(pos)) - longint'($signed(org));
      mag = (d < 0) ? -d : d;
      prod = mag * {32'd0, scl};
      if (prod > (64'd1 << 40)) prod = 64'd1 << 40;
      t = (d < 0) ? -longint'(prod) : longint'(prod);
      t = t - 32768;
      idx = t >>> 16;
      frac = t & 64'hFFFF;
   endfunction

   // addresses of the four clamped neighbors; zero when the sample reads nothing
   function automatic bit texel_corners(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                        output int corner_addr [4], output longint wx,
                                        output longint wy);
      longint ix, iy, cols, rows, x0, x1, y0, y1;
      if (cfg_scale_x == 0 || cfg_scale_y == 0 || cfg_cols == 0 || cfg_rows == 0) return 1'b0;
      cols = span_of(cfg_cols);
      rows = span_of(cfg_rows);
      map_axis(px, cfg_org_x, cfg_scale_x, ix, wx);
      map_axis(py, cfg_org_y, cfg_scale_y, iy, wy);
      x0 = clamp_idx(ix, cols);
      x1 = clamp_idx(ix + 1, cols);
      y0 = clamp_idx(iy, rows);
      y1 = clamp_idx(iy + 1, rows);
      corner_addr[0] = int'(y0 * MAX_GRID_DIM + x0);
      corner_addr[1] = int'(y0 * MAX_GRID_DIM + x1);
      corner_addr[2] = int'(y1 * MAX_GRID_DIM + x0);
      corner_addr[3] = int'(y1 * MAX_GRID_DIM + x1);
      return 1'b1;
   endfunction

   function automatic height_rsp_type compute_height_response(
      input logic op, input logic [7:0] col, input logic [7:0] row,
      input logic signed [HEIGHT_W-1:0] h, input logic [POS_W-1:0] px,
      input logic [POS_W-1:0] py);
      height_rsp_type r;
      int          a [4];
      longint      wx, wy, top, bot, acc;
      r.height = '0;
      if (op == OP_LOAD) begin
         height_mem[{row, col}] = h;
         texel_written[{row, col}] = 1'b1;
         if (!any_height) begin
            lowest_height = h;
            highest_height = h;
            any_height = 1'b1;
         end else begin
            if (h < lowest_height) lowest_height = h;
            if (h > highest_height) highest_height = h;
         end
      end else if (texel_corners(px, py, a, wx, wy)) begin
         top = longint'(height_mem[a[0]]) * (65536 - wx) + longint'(height_mem[a[1]]) * wx;
         bot = longint'(height_mem[a[2]]) * (65536 - wx) + longint'(height_mem[a[3]]) * wx;
         // round half up
         acc = (top * (65536 - wy) + bot * wy + (longint'(1) <<< 31)) >>> 32;
         r.height = acc[HEIGHT_W-1:0];
      end
      r.lowest = lowest_height;
      r.highest = highest_height;
      return r;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic send_item(input logic op, input logic [7:0] col, input logic [7:0] row,
                            input logic [HEIGHT_W-1:0] h, input logic [POS_W-1:0] px,
                            input logic [POS_W-1:0] py);
      int gap;
      gap = gap_cycles(req_idle_on);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {py, px, h, row, col};
      do @(posedge clock); while (!req_tready);
      height_expect_q.push_back(compute_height_response(op, col, row, h, px, py));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic load_texel(input logic [7:0] col, input logic [7:0] row,
                             input logic [HEIGHT_W-1:0] h);
      send_item(OP_LOAD, col, row, h, $urandom, $urandom);
   endtask

   // neighbors never written are loaded first
   task automatic sample_at(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
      int     a [4];
      longint wx, wy;
      if (texel_corners(px, py, a, wx, wy)) begin
         foreach (a[k]) begin
            if (!texel_written[a[k]]) load_texel(8'(a[k]), 8'(a[k] >> 8), 24'($urandom));
         end
      end
      send_item(OP_SAMPLE, 8'($urandom), 8'($urandom), 24'($urandom), px, py);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (height_expect_q.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GRID_COLUMNS: cfg_cols = data[DIM_W-1:0];
         CSR_GRID_ROWS:    cfg_rows = data[DIM_W-1:0];
         CSR_ORIGIN_X:     cfg_org_x = data;
         CSR_ORIGIN_Y:     cfg_org_y = data;
         CSR_SCALE_X:      cfg_scale_x = data;
         CSR_SCALE_Y:      cfg_scale_y = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
                             input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] sx, input logic [31:0] sy);
      drain();
      csr_write(CSR_GRID_COLUMNS, {23'd0, cols});
      csr_write(CSR_GRID_ROWS, {23'd0, rows});
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_SCALE_X, sx);
      csr_write(CSR_SCALE_Y, sy);
   endtask

   function automatic logic [DIM_W-1:0] rand_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return DIM_W'($urandom_range(1, 16));
      if (r < 85) return DIM_W'($urandom_range(17, 256));
      if (r < 92) return 9'd256;
      if (r < 95) return 9'd0;
      return DIM_W'($urandom_range(257, 511));
   endfunction

   function automatic logic [31:0] rand_origin();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return int'($urandom_range(0, 2000)) - 1000;
      if (r < 88) return $urandom;
      return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   function automatic logic [31:0] rand_scale();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(32'h2000, 32'h30000);
      if (r < 80) return $urandom;
      if (r < 90) return $urandom_range(1, 32'h1000);
      if (r < 95) return 32'hFFFF_FFFF;
      return 32'd0;
   endfunction

   // position whose grid coordinate lands on or just beside the grid
   function automatic logic [31:0] near_pos(input logic [31:0] org, input logic [31:0] scl,
                                            input int span);
      longint g, p;
      if (scl == 0) return $urandom;
      g = longint'($urandom_range(0, (span + 2) * 65536)) - 65536;
      p = longint'($signed(org)) + g / longint'(scl) + longint'($urandom_range(0, 1));
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   task automatic random_item();
      int r;
      int cols;
      int rows;
      r = $urandom_range(0, 99);
      cols = span_of(cfg_cols);
      rows = span_of(cfg_rows);
      if (r < 35)
         load_texel(8'($urandom_range(0, cols - 1)), 8'($urandom_range(0, rows - 1)),
                    24'($urandom));
      else if (r < 45)
         load_texel(8'($urandom), 8'($urandom), 24'($urandom));
      else if (r < 88)
         sample_at(near_pos(cfg_org_x, cfg_scale_x, cols), near_pos(cfg_org_y, cfg_scale_y, rows));
      else
         sample_at($urandom, $urandom);
   endtask

   // reset values: zero scale, so samples read nothing and extremes stay zero
   task automatic test_power_on();
      sample_at(32'h7FFF_FFFF, 32'h8000_0000);
      sample_at($urandom, $urandom);
      sample_at(32'd0, 32'd0);
   endtask

   task automatic test_directed_cases();
      set_config(9'd4, 9'd4, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000);
      load_texel(8'd0, 8'd0, 24'h7FFFFF);
      load_texel(8'd1, 8'd0, 24'h800000);
      load_texel(8'd0, 8'd1, 24'h000000);
      load_texel(8'd1, 8'd1, 24'h000100);
      // outside the grid but inside the store
      load_texel(8'd255, 8'd255, 24'hFFFFFF);
      load_texel(8'd3, 8'd3, 24'h0123AB);
      sample_at(32'd1, 32'd1);
      sample_at(32'd0, 32'd0);
      sample_at(32'd2, 32'd3);
      sample_at(32'd100, -32'sd100);
      set_config(9'd4, 9'd4, 32'd0, 32'd0, 32'h0001_8000, 32'h0000_6000);
      sample_at(32'd2, 32'd7);
      // far positions saturate the coordinate
      set_config(9'd4, 9'd4, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      sample_at(32'h7FFF_FFFF, 32'h8000_0000);
      sample_at(32'h8000_0000, 32'h7FFF_FFFF);
      set_config(9'd0, 9'd4, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000);
      sample_at(32'd1, 32'd1);
      set_config(9'd4, 9'd4, 32'd0, 32'd0, 32'h0001_0000, 32'd0);
      sample_at(32'd1, 32'd1);
      set_config(9'd1, 9'd1, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000);
      sample_at(32'd5, 32'd5);
      // oversized grid counts as the full store
      set_config(9'd300, 9'd511, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000);
      sample_at(32'd300, 32'd300);
      drain();
      csr_write(CSR_UNMAPPED, $urandom);
      sample_at(32'd255, 32'd256);
   endtask

   task automatic test_random_phases();
      int phase_len;
      while (items_sent < RANDOM_GOAL) begin
         set_config(rand_dim(), rand_dim(), rand_origin(), rand_origin(), rand_scale(),
                    rand_scale());
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(60, 160);
         repeat (phase_len) random_item();
      end
   endtask

   task automatic test_output_stall();
      set_config(9'd8, 9'd8, 32'd0, 32'd0, 32'h0000_C000, 32'h0001_4000);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      rsp_hold_request = 1'b1;
      repeat (40) random_item();
   endtask

   initial begin : rsp_ready_gen
      int wait_left;
      rsp_tready = 1'b0;
      wait_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         if (wait_left > 0) begin
            rsp_tready = 1'b0;
            wait_left--;
         end else begin
            rsp_tready = 1'b1;
            wait_left = gap_cycles(rsp_idle_on);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      height_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (height_expect_q.size() == 0) begin
            report_error($sformatf("item %h with no request pending", rsp_tdata));
         end else begin
            want = height_expect_q.pop_front();
            if (rsp_tdata[23:0] !== want.height)
               report_error($sformatf("height_out %h expected %h", rsp_tdata[23:0],
                                      want.height));
            if (rsp_tdata[47:24] !== want.lowest)
               report_error($sformatf("min_height %h expected %h", rsp_tdata[47:24],
                                      want.lowest));
            if (rsp_tdata[71:48] !== want.highest)
               report_error($sformatf("max_height %h expected %h", rsp_tdata[71:48],
                                      want.highest));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_power_on();
      test_directed_cases();
      test_random_phases();
      test_output_stall();
      drain();
      repeat (END_WAIT) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
